[rtl/bgsub_pkg.sv]
package bgsub_pkg;

    // Frame geometry and model store size
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;
    localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(PIXEL_COUNT);

    typedef logic [ADDR_W-1:0] addr_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_RATE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DEVIATION = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  RST_DEVIATION_FACTOR  = 8'd48;
    localparam logic [7:0]  RST_REFRESH_RATE      = 8'd13;
    localparam logic [15:0] RST_INITIAL_DEVIATION = 16'd2560;

    // One half in Q8.8, used for the static test and blend rounding
    localparam logic [15:0] HALF_Q88 = 16'd128;

    typedef struct packed {
        logic [7:0]  deviation_factor;
        logic [7:0]  refresh_rate;
        logic [15:0] initial_deviation;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
        logic       init_frame;
    } in_item_t;

    typedef struct packed {
        logic       moving;
        logic [7:0] background;
        logic [7:0] deviation;
    } out_item_t;

endpackage

[rtl/adaptive_background_subtractor.sv]
// Adaptive background subtractor: takes gray pixels in raster order and returns
// one result per pixel (moving flag, integer background and deviation) from the
// output register after stages 1 to 3. The per-pixel mean and deviation live in a
// 320x240-entry store that is read as a pixel enters and written back three
// stages later; a pixel whose address matches one of those three stages is held
// at the input until that update lands, as for frame_start on back-to-back
// pixels. Otherwise the rate is one pixel per clock while m_ready is high. The
// store has no reset: the first frame must be sent with init_frame set. Change
// the registers only while idle.
module adaptive_background_subtractor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bgsub_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bgsub_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bgsub_pkg::out_item_t                m_data
);
    import bgsub_pkg::*;

    cfg_t  cfg;
    addr_t addr;
    logic  accept;

    assign accept = s_valid && s_ready;

    bgsub_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgsub_addr u_addr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .frame_start (s_data.frame_start),
        .addr        (addr)
    );

    bgsub_pipe u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .addr_in (addr),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/bgsub_cfg.sv]
module bgsub_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bgsub_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data,
    output bgsub_pkg::cfg_t                     cfg
);
    import bgsub_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Take every write request at once
    assign cfg_ready = 1'b1;

    // Decode register index, drop unknown ones
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_DEVIATION_FACTOR:  cfg_next.deviation_factor  = cfg_data[7:0];
                CFG_REFRESH_RATE:      cfg_next.refresh_rate      = cfg_data[7:0];
                CFG_INITIAL_DEVIATION: cfg_next.initial_deviation = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deviation_factor  <= RST_DEVIATION_FACTOR;
            cfg_reg.refresh_rate      <= RST_REFRESH_RATE;
            cfg_reg.initial_deviation <= RST_INITIAL_DEVIATION;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bgsub_addr.sv]
module bgsub_addr (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 frame_start,
    output bgsub_pkg::addr_t     addr
);
    import bgsub_pkg::*;

    localparam addr_t LAST_ADDR = ADDR_W'(PIXEL_COUNT - 1);

    addr_t cnt_reg;
    addr_t cnt_next;

    // Frame start forces address zero for this pixel
    assign addr = frame_start ? '0 : cnt_reg;

    // Advance in raster order, wrap after the last pixel
    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = (addr == LAST_ADDR) ? '0 : addr + addr_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/bgsub_pipe.sv]
module bgsub_pipe (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bgsub_pkg::cfg_t         cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  bgsub_pkg::in_item_t     s_data,
    input  bgsub_pkg::addr_t        addr_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output bgsub_pkg::out_item_t    m_data
);
    import bgsub_pkg::*;

    // Model store: mean in the upper half, deviation in the lower half
    logic [31:0] mem [PIXEL_COUNT];

    // Stage valid bits and per-stage advance enables
    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic en1, en2, en3, en_out;
    logic hazard, accept, wr_en;

    // Stage 1 registers
    logic [31:0] rd_reg;
    logic [7:0]  pix1_reg;
    logic        init1_reg;
    addr_t       addr1_reg;

    // Stage 2 registers
    logic [7:0]  pix2_reg;
    logic        init2_reg;
    addr_t       addr2_reg;
    logic [15:0] m2_reg, d2_reg, cur2_reg;
    logic [23:0] prod2_reg;

    // Stage 3 registers
    logic [7:0]  pix3_reg;
    logic        init3_reg;
    logic        static3_reg;
    addr_t       addr3_reg;
    logic [15:0] m3_reg, d3_reg;
    logic [24:0] pma3_reg, pda3_reg;
    logic [23:0] pmb3_reg, pdb3_reg;

    out_item_t   out_reg;

    // Stage 1 logic
    logic [15:0] m1, d1, p8_1, cur1;
    logic [23:0] prod1;

    // Stage 2 logic
    logic [19:0] thr_full;
    logic [15:0] thr2, p8_2;
    logic        static2;
    logic [8:0]  keep_w;
    logic [24:0] pma2, pda2;
    logic [23:0] pmb2, pdb2;

    // Stage 3 logic
    logic [24:0] sum_m, sum_d;
    logic [15:0] mean3, dev3;
    logic        moving3;

    // Ready chain: a stage loads when empty or when its content moves on
    assign en_out = !ov_reg || m_ready;
    assign en3    = !v3_reg || en_out;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    // Hold a request whose entry is still being updated further down
    assign hazard = (v1_reg && (addr1_reg == addr_in)) ||
                    (v2_reg && (addr2_reg == addr_in)) ||
                    (v3_reg && (addr3_reg == addr_in));

    assign s_ready = en1 && !hazard;
    assign accept  = s_valid && s_ready;
    assign wr_en   = v3_reg && en_out;

    // Store read at entry, write back on leaving stage 3
    always_ff @(posedge aclk) begin
        if (en1) begin
            rd_reg <= mem[addr_in];
        end
        if (wr_en) begin
            mem[addr3_reg] <= {mean3, dev3};
        end
    end

    // Stage 1: current deviation and threshold product
    assign m1    = rd_reg[31:16];
    assign d1    = rd_reg[15:0];
    assign p8_1  = {pix1_reg, 8'd0};
    assign cur1  = (p8_1 >= m1) ? (p8_1 - m1) : (m1 - p8_1);
    assign prod1 = 24'(cfg.deviation_factor) * 24'(d1);

    // Stage 2: saturate threshold, test static, form blend products
    assign thr_full = prod2_reg[23:4];
    assign thr2     = (|thr_full[19:16]) ? 16'hFFFF : thr_full[15:0];
    assign static2  = {1'b0, thr2} > ({1'b0, cur2_reg} + {1'b0, HALF_Q88});
    assign keep_w   = 9'd256 - {1'b0, cfg.refresh_rate};
    assign p8_2     = {pix2_reg, 8'd0};
    assign pma2     = 25'(keep_w) * 25'(m2_reg);
    assign pmb2     = 24'(cfg.refresh_rate) * 24'(p8_2);
    assign pda2     = 25'(keep_w) * 25'(d2_reg);
    assign pdb2     = 24'(cfg.refresh_rate) * 24'(cur2_reg);

    // Stage 3: finish blends and pick the new model values
    assign sum_m = pma3_reg + {1'b0, pmb3_reg} + {9'd0, HALF_Q88};
    assign sum_d = pda3_reg + {1'b0, pdb3_reg} + {9'd0, HALF_Q88};

    always_comb begin
        moving3 = 1'b0;
        if (init3_reg) begin
            mean3 = {pix3_reg, 8'd0};
            dev3  = cfg.initial_deviation;
        end else if (static3_reg) begin
            mean3 = sum_m[23:8];
            dev3  = sum_d[23:8];
        end else begin
            moving3 = 1'b1;
            mean3   = m3_reg;
            dev3    = d3_reg;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg <= accept;
            if (en2)    v2_reg <= v1_reg;
            if (en3)    v3_reg <= v2_reg;
            if (en_out) ov_reg <= v3_reg;
        end
    end

    // Payload registers advance with their stage
    always_ff @(posedge aclk) begin
        if (en1) begin
            pix1_reg  <= s_data.pixel;
            init1_reg <= s_data.init_frame;
            addr1_reg <= addr_in;
        end
        if (en2) begin
            pix2_reg  <= pix1_reg;
            init2_reg <= init1_reg;
            addr2_reg <= addr1_reg;
            m2_reg    <= m1;
            d2_reg    <= d1;
            cur2_reg  <= cur1;
            prod2_reg <= prod1;
        end
        if (en3) begin
            pix3_reg    <= pix2_reg;
            init3_reg   <= init2_reg;
            static3_reg <= static2;
            addr3_reg   <= addr2_reg;
            m3_reg      <= m2_reg;
            d3_reg      <= d2_reg;
            pma3_reg    <= pma2;
            pmb3_reg    <= pmb2;
            pda3_reg    <= pda2;
            pdb3_reg    <= pdb2;
        end
        if (en_out) begin
            out_reg.moving     <= moving3;
            out_reg.background <= mean3[15:8];
            out_reg.deviation  <= dev3[15:8];
        end
    end

    assign m_valid = ov_reg;
    assign m_data  = out_reg;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import bgsub_pkg::*;

    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int RANDOM_ITEMS     = 800;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 16;
    localparam int MAX_GAP          = 11;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;

    // Background model as the block should hold it
    logic [15:0] model_mean [PIXEL_COUNT];
    logic [15:0] model_dev [PIXEL_COUNT];
    bit          model_written [PIXEL_COUNT];
    int unsigned model_addr = 0;
    logic [7:0]  cfg_factor = RST_DEVIATION_FACTOR;
    logic [7:0]  cfg_rate = RST_REFRESH_RATE;
    logic [15:0] cfg_init_dev = RST_INITIAL_DEVIATION;

    out_item_t   pending_verdicts [$];
    out_item_t   want;
    int          error_count = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          src_gaps;
    bit          sink_gaps;
    bit          sink_hold_req = 0;

    adaptive_background_subtractor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Move a Q8.8 value toward its target by rate/256, rounded
    function automatic logic [15:0] blend_q88(logic [15:0] old, logic [15:0] target,
                                              logic [7:0] rate);
        logic [25:0] acc;
        acc = (26'd256 - 26'(rate)) * 26'(old) + 26'(rate) * 26'(target) + 26'd128;
        return acc[23:8];
    endfunction

    // Classify one pixel and update the background model at its address
    function automatic out_item_t classify_pixel(in_item_t px);
        int unsigned addr;
        logic [15:0] p8, m, d, cur, thr;
        logic [23:0] prod;
        out_item_t   res;
        if (px.frame_start) model_addr = 0;
        addr = model_addr;
        p8 = {px.pixel, 8'h00};
        res.moving = 1'b0;
        if (px.init_frame) begin
            m = p8;
            d = cfg_init_dev;
        end else begin
            m = model_mean[addr];
            d = model_dev[addr];
            cur = (p8 >= m) ? p8 - m : m - p8;
            prod = 24'(cfg_factor) * 24'(d);
            thr = (prod[23:20] != 4'd0) ? 16'hFFFF : prod[19:4];
            // static only when the threshold clears the deviation by over one half
            if ({1'b0, thr} > {1'b0, cur} + 17'd128) begin
                m = blend_q88(m, p8, cfg_rate);
                d = blend_q88(d, cur, cfg_rate);
            end else begin
                res.moving = 1'b1;
            end
        end
        model_mean[addr] = m;
        model_dev[addr] = d;
        model_written[addr] = 1'b1;
        model_addr = (addr == PIXEL_COUNT - 1) ? 0 : addr + 1;
        res.background = m[15:8];
        res.deviation = d[15:8];
        return res;
    endfunction

    function automatic logic [15:0] pick_cfg_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one pixel request; load it from scratch if its entry was never written
    task automatic send_pixel(input logic [7:0] px, input logic start, input logic init);
        int unsigned addr;
        int          gap;
        in_item_t    item;
        out_item_t   verdict;
        addr = start ? 0 : model_addr;
        item.pixel = px;
        item.frame_start = start;
        item.init_frame = init | ~model_written[addr];
        gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = item;
        do @(posedge aclk); while (!s_ready);
        verdict = classify_pixel(item);
        pending_verdicts.insert(pending_verdicts.size(), verdict);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DEVIATION_FACTOR:  cfg_factor = value[7:0];
            CFG_REFRESH_RATE:      cfg_rate = value[7:0];
            CFG_INITIAL_DEVIATION: cfg_init_dev = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    // Extremes of the pixel, static and moving, repeated addresses
    task automatic test_directed_basics();
        send_pixel(8'd0, 1'b1, 1'b1);
        send_pixel(8'd255, 1'b0, 1'b1);
        send_pixel(8'd128, 1'b0, 1'b1);
        send_pixel(8'd0, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd130, 1'b0, 1'b0);
        // frame start on back-to-back pixels hits the same entry
        send_pixel(8'd7, 1'b1, 1'b0);
        send_pixel(8'd9, 1'b1, 1'b0);
        send_pixel(8'd250, 1'b1, 1'b0);
        send_pixel(8'd60, 1'b1, 1'b1);
        send_pixel(8'd61, 1'b1, 1'b1);
        send_pixel(8'd61, 1'b0, 1'b0);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        // zero factor: nothing can be static; upper data bits must be dropped
        write_reg(CFG_DEVIATION_FACTOR, 16'hFF00);
        send_pixel(8'd100, 1'b1, 1'b1);
        send_pixel(8'd100, 1'b1, 1'b0);
        wait_idle();
        // saturate the threshold
        write_reg(CFG_DEVIATION_FACTOR, 16'h01FF);
        write_reg(CFG_INITIAL_DEVIATION, 16'hFFFF);
        send_pixel(8'd0, 1'b1, 1'b1);
        send_pixel(8'd255, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_REFRESH_RATE, 16'h0000);
        send_pixel(8'd200, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_REFRESH_RATE, 16'hFFFF);
        send_pixel(8'd10, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_INITIAL_DEVIATION, 16'h0000);
        send_pixel(8'd77, 1'b1, 1'b1);
        send_pixel(8'd77, 1'b1, 1'b0);
        wait_idle();
        // write to an unmapped index must change nothing
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_pixel(8'd77, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_DEVIATION_FACTOR, {8'h00, RST_DEVIATION_FACTOR});
        write_reg(CFG_REFRESH_RATE, {8'h00, RST_REFRESH_RATE});
        write_reg(CFG_INITIAL_DEVIATION, RST_INITIAL_DEVIATION);
    endtask

    // Short frames near the background, mixed with noise requests
    task automatic test_random_frames();
        int unsigned goal, next_phase, len, addr;
        int          amp, v;
        logic        init;
        goal = items_sent + RANDOM_ITEMS;
        next_phase = items_sent;
        while (items_sent < goal) begin
            // retune registers and idling between phases
            if (items_sent >= next_phase) begin
                wait_idle();
                if ($urandom_range(0, 1)) write_reg(CFG_DEVIATION_FACTOR, pick_cfg_value());
                if ($urandom_range(0, 1)) write_reg(CFG_REFRESH_RATE, pick_cfg_value());
                if ($urandom_range(0, 1)) write_reg(CFG_INITIAL_DEVIATION, pick_cfg_value());
                if ($urandom_range(0, 7) == 0) write_reg(CFG_UNMAPPED, pick_cfg_value());
                src_gaps = ($urandom_range(0, 3) != 0);
                sink_gaps = ($urandom_range(0, 3) != 0);
                next_phase = items_sent + $urandom_range(60, 140);
            end
            if ($urandom_range(0, 4) != 0) begin
                len = $urandom_range(1, 48);
                init = ($urandom_range(0, 5) == 0);
                case ($urandom_range(0, 3))
                    0: amp = 2;
                    1: amp = 8;
                    2: amp = 40;
                    default: amp = 255;
                endcase
                for (int i = 0; i < len; i++) begin
                    addr = (i == 0) ? 0 : model_addr;
                    v = int'(model_mean[addr][15:8]) + int'($urandom_range(0, 2 * amp)) - amp;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    send_pixel(8'(v), i == 0, init);
                end
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    send_pixel(8'($urandom), $urandom_range(0, 7) == 0,
                               $urandom_range(0, 7) == 0);
                end
            end
        end
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_output_backpressure();
        wait_idle();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        sink_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_pixel(model_written[i] ? model_mean[i][15:8] : 8'($urandom), i == 0, 1'b0);
        end
        wait_idle();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // Result side: stall at random, or for a long stretch on request
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                m_ready = 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                sink_hold_req = 1'b0;
            end
            stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no request outstanding: %h", m_data);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data.moving !== want.moving) begin
                    $error("moving: expected %0d, got %0d", want.moving, m_data.moving);
                    error_count++;
                end
                if (m_data.background !== want.background) begin
                    $error("background: expected %0d, got %0d",
                           want.background, m_data.background);
                    error_count++;
                end
                if (m_data.deviation !== want.deviation) begin
                    $error("deviation: expected %0d, got %0d",
                           want.deviation, m_data.deviation);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEVIATION_FACTOR;
        cfg_data = 16'h0000;
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_basics();
        test_register_extremes();
        test_random_frames();
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
